FILE: sv/openpgp_packet_header_walker_defines.svh
// assertion macros for the openpgp packet header walker
`ifndef OPENPGP_PACKET_HEADER_WALKER_DEFINES_SVH
`define OPENPGP_PACKET_HEADER_WALKER_DEFINES_SVH

// same-cycle implication, checked on aclk, quiet during reset
`define OPHW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk, quiet during reset
`define OPHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ophw_pkg.sv
// shared types and constants for the openpgp packet header walker
package ophw_pkg;

    // walk phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_TAG       = 5'b00010,
        PH_LEN_FIRST = 5'b00100,
        PH_LEN_MORE  = 5'b01000,
        PH_BODY      = 5'b10000
    } phase_t;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_TAG     = 3'd1;
    localparam logic [2:0] ERR_INDET_LEN   = 3'd2;
    localparam logic [2:0] ERR_INVALID_LEN = 3'd3;
    localparam logic [2:0] ERR_OVERRUN     = 3'd4;

    // configuration register indexes
    localparam logic REG_SUBPACKET_MODE = 1'b0;
    localparam logic REG_REGION_SIZE    = 1'b1;

    // length coding limits
    localparam logic [7:0] LEN_TWO_BYTE_MIN = 8'd192;
    localparam logic [7:0] LEN_PARTIAL_MIN  = 8'd224;
    localparam logic [7:0] LEN_FIVE_BYTE    = 8'd255;

    // old-format length type that means indeterminate
    localparam logic [1:0] OLD_LEN_INDET = 2'b11;

endpackage

FILE: sv/openpgp_packet_header_walker.sv
// OpenPGP packet and subpacket header walker, one region byte per request.
// Takes one byte per clock cycle, back to back, unless a stalled result port holds
// it off, and returns the decoded header result through the input register, where the
// whole per-byte state update is done, and then through the result register. Packet
// bodies are skipped without results. In packet mode it decodes new-format tags
// with 1, 2 or 5 byte lengths and old-format tags with 1, 2 or 4 byte lengths;
// in subpacket mode the length comes first and the type byte follows. A request
// with start_req set begins a walk at offset zero; the walk stops at the region
// end or on the first error, and bytes after that are dropped until the next
// start. Configuration (index 0 subpacket_mode, index 1 region_size) is meant to
// be written while the walker is idle. A stalled result port holds off input
// once the input and result registers are both full.
module openpgp_packet_header_walker
    import ophw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    // header results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_header_valid,
    output logic [7:0]  m_packet_type,
    output logic [31:0] m_body_length,
    output logic [31:0] m_header_offset,
    output logic [2:0]  m_error_code,
    output logic        m_walk_done
);

`include "openpgp_packet_header_walker_defines.svh"

    // configuration registers
    logic        subpacket_mode_reg;
    logic [31:0] region_size_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // walk state
    phase_t      phase_reg, phase_next;
    logic        stopped_reg, stopped_next;
    logic [2:0]  hbs_reg, hbs_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  flb_reg, flb_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] body_reg, body_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] pstart_reg, pstart_next;

    // result register
    logic        m_valid_reg;
    logic        res_hv_reg;
    logic [7:0]  res_type_reg;
    logic [31:0] res_len_reg;
    logic [31:0] res_off_reg;
    logic [2:0]  res_err_reg;
    logic        res_done_reg;

    logic advance;

    // current state, with a start request taking effect first
    phase_t      first_phase;
    phase_t      cur_phase;
    logic        cur_stopped;
    logic [2:0]  cur_hbs;
    logic [7:0]  cur_tag;
    logic [7:0]  cur_flb;
    logic [31:0] cur_acc;
    logic [31:0] cur_body;
    logic [31:0] cur_off;
    logic [31:0] cur_pstart;

    // datapath helpers
    logic [32:0] off_inc;
    logic        last_byte;
    logic [31:0] acc_shift;
    logic [2:0]  hbs_inc;
    logic        short_form;
    logic [2:0]  bytes_needed;
    logic        len_complete;
    logic [23:0] flb_minus;
    logic [31:0] len_more;
    logic [31:0] ld_len;
    logic [31:0] hd_len;
    logic [7:0]  hd_type;
    logic [32:0] hdr_end;
    logic        end_over;
    logic [31:0] body_dec;

    // result of this step
    logic        emit;
    logic        r_hv;
    logic [7:0]  r_type;
    logic [31:0] r_len;
    logic [2:0]  r_err;
    logic        r_done;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        do_hdr;
    logic        do_lend;
    logic        chk_last;

    // handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subpacket_mode_reg <= 1'b0;
            region_size_reg    <= 32'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SUBPACKET_MODE: subpacket_mode_reg <= cfg_wdata[0];
                REG_REGION_SIZE:    region_size_reg    <= cfg_wdata;
                default:            subpacket_mode_reg <= subpacket_mode_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_start_req;
        end
    end

    // state seen by this byte
    assign first_phase = subpacket_mode_reg ? PH_LEN_FIRST : PH_TAG;
    assign cur_phase   = in_start_reg ? first_phase : phase_reg;
    assign cur_stopped = in_start_reg ? 1'b0  : stopped_reg;
    assign cur_hbs     = in_start_reg ? 3'd0  : hbs_reg;
    assign cur_tag     = in_start_reg ? 8'd0  : tag_reg;
    assign cur_flb     = in_start_reg ? 8'd0  : flb_reg;
    assign cur_acc     = in_start_reg ? 32'd0 : acc_reg;
    assign cur_body    = in_start_reg ? 32'd0 : body_reg;
    assign cur_off     = in_start_reg ? 32'd0 : offset_reg;
    assign cur_pstart  = in_start_reg ? 32'd0 : pstart_reg;

    // offset and region end
    assign off_inc   = {1'b0, cur_off} + 33'd1;
    assign last_byte = off_inc >= {1'b0, region_size_reg};

    // multi-byte length gathering
    assign acc_shift  = {cur_acc[23:0], in_byte_reg};
    assign hbs_inc    = cur_hbs + 3'd1;
    assign short_form = subpacket_mode_reg || cur_tag[6];
    always_comb begin
        if (short_form) begin
            bytes_needed = (cur_flb == LEN_FIVE_BYTE) ? 3'd4 : 3'd1;
        end else if (cur_tag[1]) begin
            bytes_needed = 3'd4;
        end else begin
            bytes_needed = {2'b00, cur_tag[0]} + 3'd1;
        end
    end
    assign len_complete = hbs_inc >= bytes_needed;
    assign flb_minus    = {16'd0, cur_flb} - {16'd0, LEN_TWO_BYTE_MIN};
    assign len_more     = (short_form && cur_flb != LEN_FIVE_BYTE)
                        ? ({flb_minus, 8'd0} + {24'd0, acc_shift[7:0]}
                           + {24'd0, LEN_TWO_BYTE_MIN})
                        : acc_shift;
    assign ld_len = (cur_phase == PH_LEN_FIRST) ? {24'd0, in_byte_reg} : len_more;

    // header completion: type, length and region bound
    assign hd_len  = (cur_phase == PH_TAG) ? cur_acc : ld_len;
    assign hd_type = (cur_phase == PH_TAG) ? in_byte_reg
                   : (cur_tag[6] ? {2'b00, cur_tag[5:0]} : {4'b0000, cur_tag[5:2]});
    assign hdr_end  = {1'b0, off_inc[31:0]} + {1'b0, hd_len};
    assign end_over = hdr_end > {1'b0, region_size_reg};

    assign body_dec = (cur_body != 32'd0) ? cur_body - 32'd1 : cur_body;

    // per-byte walk step
    always_comb begin
        phase_next  = cur_phase;
        stopped_next = cur_stopped;
        hbs_next    = cur_hbs;
        tag_next    = cur_tag;
        flb_next    = cur_flb;
        acc_next    = cur_acc;
        body_next   = cur_body;
        offset_next = cur_off;
        pstart_next = cur_pstart;
        emit      = 1'b0;
        r_hv      = 1'b0;
        r_type    = 8'd0;
        r_len     = 32'd0;
        r_err     = ERR_NONE;
        r_done    = 1'b0;
        do_fail   = 1'b0;
        fail_code = ERR_NONE;
        do_hdr    = 1'b0;
        do_lend   = 1'b0;
        chk_last  = 1'b0;

        if (in_start_reg && region_size_reg == 32'd0) begin
            // empty region ends at once
            emit         = 1'b1;
            r_done       = 1'b1;
            stopped_next = 1'b1;
            phase_next   = PH_IDLE;
        end else if (!cur_stopped) begin
            offset_next = off_inc[31:0];
            unique case (cur_phase)
                PH_TAG: begin
                    tag_next = in_byte_reg;
                    if (subpacket_mode_reg) begin
                        do_hdr = 1'b1;
                    end else if (!in_byte_reg[7]) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_BAD_TAG;
                    end else if (in_byte_reg[6]) begin
                        phase_next = PH_LEN_FIRST;
                        chk_last   = 1'b1;
                    end else if (in_byte_reg[1:0] == OLD_LEN_INDET) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_INDET_LEN;
                    end else begin
                        hbs_next   = 3'd0;
                        acc_next   = 32'd0;
                        phase_next = PH_LEN_MORE;
                        chk_last   = 1'b1;
                    end
                end
                PH_LEN_FIRST: begin
                    flb_next = in_byte_reg;
                    if (in_byte_reg < LEN_TWO_BYTE_MIN) begin
                        do_lend = 1'b1;
                    end else if (in_byte_reg != LEN_FIVE_BYTE
                                 && in_byte_reg >= LEN_PARTIAL_MIN) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_INVALID_LEN;
                    end else begin
                        hbs_next   = 3'd0;
                        acc_next   = 32'd0;
                        phase_next = PH_LEN_MORE;
                        chk_last   = 1'b1;
                    end
                end
                PH_LEN_MORE: begin
                    acc_next = acc_shift;
                    hbs_next = hbs_inc;
                    if (len_complete) begin
                        do_lend = 1'b1;
                    end else begin
                        chk_last = 1'b1;
                    end
                end
                PH_BODY: begin
                    body_next = body_dec;
                    if (body_dec == 32'd0) begin
                        if (last_byte) begin
                            emit         = 1'b1;
                            r_done       = 1'b1;
                            stopped_next = 1'b1;
                            phase_next   = PH_IDLE;
                        end else begin
                            pstart_next = off_inc[31:0];
                            phase_next  = first_phase;
                        end
                    end
                end
                default: begin
                    stopped_next = 1'b1;
                    phase_next   = PH_IDLE;
                end
            endcase

            // length complete: subpacket waits for its type byte
            if (do_lend) begin
                if (subpacket_mode_reg) begin
                    if (ld_len == 32'd0) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_INVALID_LEN;
                    end else begin
                        acc_next   = ld_len - 32'd1;
                        phase_next = PH_TAG;
                        if (last_byte) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OVERRUN;
                        end
                    end
                end else begin
                    do_hdr = 1'b1;
                end
            end

            // header complete
            if (do_hdr) begin
                if (end_over) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_OVERRUN;
                end else begin
                    emit   = 1'b1;
                    r_hv   = 1'b1;
                    r_type = hd_type;
                    r_len  = hd_len;
                    if (hd_len == 32'd0) begin
                        if (last_byte) begin
                            r_done       = 1'b1;
                            stopped_next = 1'b1;
                            phase_next   = PH_IDLE;
                        end else begin
                            pstart_next = off_inc[31:0];
                            phase_next  = first_phase;
                        end
                    end else begin
                        body_next  = hd_len;
                        phase_next = PH_BODY;
                    end
                end
            end

            // header cut off by the region end
            if (chk_last && last_byte) begin
                do_fail   = 1'b1;
                fail_code = ERR_OVERRUN;
            end

            if (do_fail) begin
                emit         = 1'b1;
                r_hv         = 1'b0;
                r_type       = 8'd0;
                r_len        = 32'd0;
                r_err        = fail_code;
                r_done       = 1'b1;
                stopped_next = 1'b1;
                phase_next   = PH_IDLE;
            end
        end
    end

    // walk state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            stopped_reg <= 1'b1;
            hbs_reg     <= 3'd0;
            tag_reg     <= 8'd0;
            flb_reg     <= 8'd0;
            acc_reg     <= 32'd0;
            body_reg    <= 32'd0;
            offset_reg  <= 32'd0;
            pstart_reg  <= 32'd0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            hbs_reg     <= hbs_next;
            tag_reg     <= tag_next;
            flb_reg     <= flb_next;
            acc_reg     <= acc_next;
            body_reg    <= body_next;
            offset_reg  <= offset_next;
            pstart_reg  <= pstart_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            res_hv_reg   <= r_hv;
            res_type_reg <= r_type;
            res_len_reg  <= r_len;
            res_off_reg  <= cur_pstart;
            res_err_reg  <= r_err;
            res_done_reg <= r_done;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_header_valid  = res_hv_reg;
    assign m_packet_type   = res_type_reg;
    assign m_body_length   = res_len_reg;
    assign m_header_offset = res_off_reg;
    assign m_error_code    = res_err_reg;
    assign m_walk_done     = res_done_reg;

    // checks
    `OPHW_ASSERT_NOW(a_err_ends_walk, m_valid && m_error_code != ERR_NONE, m_walk_done && !m_header_valid, "error result without walk end")
    `OPHW_ASSERT_NOW(a_hdr_no_err, m_valid && m_header_valid, m_error_code == ERR_NONE, "header result carries an error")
    `OPHW_ASSERT_NOW(a_stop_idle, stopped_reg, phase_reg == PH_IDLE, "stopped walk not idle")
    `OPHW_ASSERT_NEXT(a_done_stops, advance && emit && r_done, stopped_reg, "walk end did not stop")

endmodule
